FILE: hw/rtl/gtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtq_pkg: shared types and constants of the grouped team queue
// Sizes, operation and status codes, and the structs that move between the
// sequencer, its memories and the top level.
// ----------------------------------------------------------------------------
package gtq_pkg;

  // Sizes (both are powers of two)
  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned TEAM_COUNT = 1024;

  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned TEAM_W   = $clog2(TEAM_COUNT);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 20;
  localparam int unsigned TEAMID_W = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 11;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_DISCARD = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DATA  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Request transaction
  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [VALUE_W-1:0]  item_value;
    logic [TEAMID_W-1:0] team_id;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  out_value;
    logic [OCC_W-1:0]    occupancy;
  } res_t;

  // Node memory word: element and its team
  typedef struct packed {
    logic [TEAM_W-1:0]  team;
    logic [VALUE_W-1:0] value;
  } node_t;

  // Team memory word: presence mark and last queued node
  typedef struct packed {
    logic             present;
    logic [IDX_W-1:0] last;
  } team_t;

endpackage

FILE: hw/rtl/gtq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtq_req_if: request channel of the grouped team queue
// Valid/ready channel carrying one operation with its element and team.
// ----------------------------------------------------------------------------
interface gtq_req_if import gtq_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [VALUE_W-1:0]  item_value;
  logic [TEAMID_W-1:0] team_id;

  modport source (output valid, output operation, output item_value, output team_id,
                  input ready);
  modport sink   (input valid, input operation, input item_value, input team_id,
                  output ready);

endinterface

FILE: hw/rtl/gtq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtq_rsp_if: response channel of the grouped team queue
// Valid/ready channel carrying status, returned element and occupancy.
// ----------------------------------------------------------------------------
interface gtq_rsp_if import gtq_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  out_value;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output out_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input out_value, input occupancy,
                  output ready);

endinterface

FILE: hw/rtl/grouped_team_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_team_queue: team queue over a linked list in node memory
// Enqueue places an element after the last queued member of its team, or at
// the tail; dequeue returns the head, discard drops it.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries operation, item_value and team_id; rsp_o returns status,
//   out_value and occupancy, one response per request, in order.
//   One request is in work at a time. After acceptance, full, empty and
//   reserved operations go straight to S_DONE. An enqueue passes S_ENQ,
//   then S_LINK at the tail or S_SPLICE and S_LINK inside a team, and
//   S_ENQ alone into an empty queue; a dequeue or discard passes S_DEQ,
//   then S_DEQ2 unless it removes the last element. The next request is
//   taken in the cycle after the response is handed to the output register.
//   The steps follow the reads and write-backs on the node, link and team
//   memories, each with a single read port.
//   After reset the block clears all TEAM_COUNT (1024) team marks, one per
//   cycle; req_i.ready stays low during that pass.
//   The response sits in an output register; while the receiver stalls a
//   finished operation waits in the sequencer and no new request is taken.
// ----------------------------------------------------------------------------
module grouped_team_queue import gtq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  gtq_req_if.sink   req_i,
  gtq_rsp_if.source rsp_o
);

  req_t req;
  res_t res, out_q, out_d;
  logic res_valid, res_ready;
  logic out_valid_q, out_valid_d;

  assign req.operation  = req_i.operation;
  assign req.item_value = req_i.item_value;
  assign req.team_id    = req_i.team_id;

  gtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Load the output register when empty or being drained
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_q.status;
  assign rsp_o.out_value = out_q.out_value;
  assign rsp_o.occupancy = out_q.occupancy;

  // Only returned elements carry data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ST_DATA)) |-> (rsp_o.out_value == '0))
    else $error("out_value nonzero without returned element");

  // Full and empty responses agree with occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_FULL)) |-> (rsp_o.occupancy == OCC_W'(CAPACITY)))
    else $error("full reported below capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_EMPTY)) |-> (rsp_o.occupancy == '0))
    else $error("empty reported with elements queued");

  // One transaction in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted on consecutive cycles");

endmodule

FILE: hw/rtl/gtq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtq_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/gtq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtq_ctrl: list sequencer of the grouped team queue
// Holds head, tail, count and slot allocation; walks each operation through
// read-modify-write steps on the node, link and team memories.
// ----------------------------------------------------------------------------
module gtq_ctrl import gtq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  // Sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ENQ    = 3'd2;
  localparam logic [2:0] S_SPLICE = 3'd3;
  localparam logic [2:0] S_LINK   = 3'd4;
  localparam logic [2:0] S_DEQ    = 3'd5;
  localparam logic [2:0] S_DEQ2   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    fresh_q, fresh_d;
  logic [IDX_W-1:0]    free_q, free_d;
  logic [TEAM_W-1:0]   clr_q, clr_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic [TEAM_W-1:0]   team_q, team_d;
  logic [IDX_W-1:0]    n_q, n_d;
  logic [IDX_W-1:0]    link_q, link_d;
  logic                move_tail_q, move_tail_d;
  logic [TEAM_W-1:0]   hteam_q, hteam_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [VALUE_W-1:0]  rval_q, rval_d;

  // Memory ports
  logic             data_we, data_re;
  logic [IDX_W-1:0] data_waddr, data_raddr;
  node_t            data_wdata, data_rdata;
  logic             next_we, next_re;
  logic [IDX_W-1:0] next_waddr, next_raddr, next_wdata, next_rdata;
  logic              team_we, team_re;
  logic [TEAM_W-1:0] team_waddr, team_raddr;
  team_t             team_wdata, team_rdata;

  logic             fresh_left;
  logic [IDX_W-1:0] slot_new;

  gtq_ram #(.WIDTH($bits(node_t)), .DEPTH(CAPACITY)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .re_i    (data_re),
    .raddr_i (data_raddr),
    .rdata_o (data_rdata)
  );

  gtq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (next_re),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  gtq_ram #(.WIDTH($bits(team_t)), .DEPTH(TEAM_COUNT)) u_team_ram (
    .clk_i   (clk_i),
    .we_i    (team_we),
    .waddr_i (team_waddr),
    .wdata_i (team_wdata),
    .re_i    (team_re),
    .raddr_i (team_raddr),
    .rdata_o (team_rdata)
  );

  // Pick a never-used slot first, then the head of the free list
  assign fresh_left = (fresh_q < CNT_W'(CAPACITY));
  assign slot_new   = fresh_left ? fresh_q[IDX_W-1:0] : free_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    free_d      = free_q;
    clr_d       = clr_q;
    val_d       = val_q;
    team_d      = team_q;
    n_d         = n_q;
    link_d      = link_q;
    move_tail_d = move_tail_q;
    hteam_d     = hteam_q;
    status_d    = status_q;
    rval_d      = rval_q;
    data_we     = 1'b0;
    data_waddr  = '0;
    data_wdata  = '0;
    data_re     = 1'b0;
    data_raddr  = '0;
    next_we     = 1'b0;
    next_waddr  = '0;
    next_wdata  = '0;
    next_re     = 1'b0;
    next_raddr  = '0;
    team_we     = 1'b0;
    team_waddr  = '0;
    team_wdata  = '0;
    team_re     = 1'b0;
    team_raddr  = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      // Clear every presence mark after reset
      S_CLEAR: begin
        team_we    = 1'b1;
        team_waddr = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == TEAM_W'(TEAM_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end

      // Take a transaction and issue the first reads
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          val_d  = req_i.item_value;
          team_d = TEAM_W'(req_i.team_id);
          rval_d = '0;
          case (req_i.operation)
            OP_ENQUEUE: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                team_re    = 1'b1;
                team_raddr = TEAM_W'(req_i.team_id);
                next_re    = 1'b1;
                next_raddr = free_q;
                status_d   = ST_DONE;
                state_d    = S_ENQ;
              end
            end
            OP_DEQUEUE, OP_DISCARD: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                data_re    = 1'b1;
                data_raddr = head_q;
                next_re    = 1'b1;
                next_raddr = head_q;
                status_d   = (req_i.operation == OP_DEQUEUE) ? ST_DATA : ST_DONE;
                state_d    = S_DEQ;
              end
            end
            default: begin
              status_d = ST_DONE;
              state_d  = S_DONE;
            end
          endcase
        end
      end

      // Allocate the node, write it and mark its team
      S_ENQ: begin
        n_d = slot_new;
        if (fresh_left) begin
          fresh_d = fresh_q + 1'b1;
        end else begin
          free_d = next_rdata;
        end
        data_we            = 1'b1;
        data_waddr         = slot_new;
        data_wdata.team    = team_q;
        data_wdata.value   = val_q;
        team_we            = 1'b1;
        team_waddr         = team_q;
        team_wdata.present = 1'b1;
        team_wdata.last    = slot_new;
        count_d            = count_q + 1'b1;
        if (count_q == '0) begin
          next_we    = 1'b1;
          next_waddr = slot_new;
          head_d     = slot_new;
          tail_d     = slot_new;
          state_d    = S_DONE;
        end else if (team_rdata.present && (team_rdata.last != tail_q)) begin
          // Insert after the team's last member: fetch its link
          next_re     = 1'b1;
          next_raddr  = team_rdata.last;
          link_d      = team_rdata.last;
          move_tail_d = 1'b0;
          state_d     = S_SPLICE;
        end else begin
          next_we     = 1'b1;
          next_waddr  = slot_new;
          link_d      = tail_q;
          move_tail_d = 1'b1;
          state_d     = S_LINK;
        end
      end

      // Inherit the link of the team's last member
      S_SPLICE: begin
        next_we    = 1'b1;
        next_waddr = n_q;
        next_wdata = next_rdata;
        state_d    = S_LINK;
      end

      // Point the predecessor at the new node
      S_LINK: begin
        next_we    = 1'b1;
        next_waddr = link_q;
        next_wdata = n_q;
        if (move_tail_q) begin
          tail_d = n_q;
        end
        state_d = S_DONE;
      end

      // Release the head slot and advance
      S_DEQ: begin
        if (status_q == ST_DATA) begin
          rval_d = data_rdata.value;
        end
        hteam_d    = data_rdata.team;
        next_we    = 1'b1;
        next_waddr = head_q;
        next_wdata = free_q;
        free_d     = head_q;
        count_d    = count_q - 1'b1;
        if (count_q == CNT_W'(1)) begin
          team_we    = 1'b1;
          team_waddr = data_rdata.team;
          head_d     = '0;
          tail_d     = '0;
          state_d    = S_DONE;
        end else begin
          data_re    = 1'b1;
          data_raddr = next_rdata;
          head_d     = next_rdata;
          state_d    = S_DEQ2;
        end
      end

      // Drop the team mark when the new head belongs to another team
      S_DEQ2: begin
        if (data_rdata.team != hteam_q) begin
          team_we    = 1'b1;
          team_waddr = hteam_q;
        end
        state_d = S_DONE;
      end

      // Hand the result over
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.status    = status_q;
  assign res_o.out_value = rval_q;
  assign res_o.occupancy = OCC_W'(count_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      fresh_q <= '0;
      free_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      fresh_q <= fresh_d;
      free_q  <= free_d;
      clr_q   <= clr_d;
    end
  end

  // Working registers of the current transaction
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    team_q      <= team_d;
    n_q         <= n_d;
    link_q      <= link_d;
    move_tail_q <= move_tail_d;
    hteam_q     <= hteam_d;
    status_q    <= status_d;
    rval_q      <= rval_d;
  end

endmodule

FILE: verif/gtq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtq_checker: response predictor and scoreboard for the grouped team queue
// Watches both channels, keeps a linked-list model of the team queue, queues
// one expected response per accepted request and compares every returned
// response field by field, in order.
// ----------------------------------------------------------------------------
module gtq_checker import gtq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gtq_req_if          req_i,
  gtq_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Model state: node memory, team table and list pointers
  logic [VALUE_W-1:0] node_value [CAPACITY];
  logic [TEAM_W-1:0]  node_team  [CAPACITY];
  logic [IDX_W-1:0]   node_next  [CAPACITY];
  logic [IDX_W-1:0]   team_last  [TEAM_COUNT];
  logic               team_present [TEAM_COUNT];
  logic [IDX_W-1:0]   free_head;
  logic [CNT_W-1:0]   fresh_next;
  logic [IDX_W-1:0]   head_ptr;
  logic [IDX_W-1:0]   tail_ptr;
  logic [CNT_W-1:0]   queued_count;

  res_t        awaited_rsp [$];
  int unsigned mismatch_total;
  int unsigned rsp_index;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: response %0d %s: got %0d, expected %0d",
             $time, rsp_index, what, got, want);
    mismatch_total++;
  endtask

  // Apply one request to the model and return the response it produces
  function automatic res_t team_queue_response(input req_t r);
    res_t              res;
    logic [IDX_W-1:0]  n;
    logic [IDX_W-1:0]  h;
    logic [IDX_W-1:0]  nx;
    logic [IDX_W-1:0]  after;
    logic [TEAM_W-1:0] t;
    res.status    = ST_DONE;
    res.out_value = '0;
    t = r.team_id[TEAM_W-1:0];
    case (r.operation)
      OP_ENQUEUE: begin
        if (queued_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // take a fresh slot first, then recycle from the free list
          if (fresh_next < CAPACITY) begin
            n = fresh_next[IDX_W-1:0];
            fresh_next++;
          end else begin
            n = free_head;
            free_head = node_next[n];
          end
          node_value[n] = r.item_value;
          node_team[n]  = t;
          node_next[n]  = '0;
          if (queued_count == 0) begin
            head_ptr = n;
            tail_ptr = n;
          end else if (team_present[t] && team_last[t] != tail_ptr) begin
            // splice in right behind the team's last member
            after           = team_last[t];
            node_next[n]     = node_next[after];
            node_next[after] = n;
          end else begin
            node_next[tail_ptr] = n;
            tail_ptr = n;
          end
          team_last[t]    = n;
          team_present[t] = 1'b1;
          queued_count++;
        end
      end
      OP_DEQUEUE, OP_DISCARD: begin
        if (queued_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          h = head_ptr;
          // clear the team mark once its block leaves the head
          if (queued_count == 1) begin
            team_present[node_team[h]] = 1'b0;
            head_ptr = '0;
            tail_ptr = '0;
          end else begin
            nx = node_next[h];
            if (node_team[nx] != node_team[h])
              team_present[node_team[h]] = 1'b0;
            head_ptr = nx;
          end
          node_next[h] = free_head;
          free_head = h;
          queued_count--;
          if (r.operation == OP_DEQUEUE) begin
            res.status    = ST_DATA;
            res.out_value = node_value[h];
          end
        end
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(queued_count);
    return res;
  endfunction

  // Predict on every request transaction, compare on every response
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    req_t seen_req;
    res_t seen_rsp;
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        node_value[i] = '0;
        node_team[i]  = '0;
        node_next[i]  = '0;
      end
      for (int i = 0; i < TEAM_COUNT; i++) begin
        team_last[i]    = '0;
        team_present[i] = 1'b0;
      end
      free_head      = '0;
      fresh_next     = '0;
      head_ptr       = '0;
      tail_ptr       = '0;
      queued_count   = '0;
      awaited_rsp.delete();
      mismatch_total = 0;
      rsp_index      = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        seen_req.operation  = req_i.operation;
        seen_req.item_value = req_i.item_value;
        seen_req.team_id    = req_i.team_id;
        awaited_rsp.push_back(team_queue_response(seen_req));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        seen_rsp.status    = rsp_i.status;
        seen_rsp.out_value = rsp_i.out_value;
        seen_rsp.occupancy = rsp_i.occupancy;
        if (awaited_rsp.size() == 0) begin
          report_mismatch("arrived with no request outstanding, occupancy",
                          32'(seen_rsp.occupancy), 32'd0);
        end else begin
          want = awaited_rsp.pop_front();
          if (seen_rsp.status !== want.status)
            report_mismatch("status", 32'(seen_rsp.status), 32'(want.status));
          if (seen_rsp.out_value !== want.out_value)
            report_mismatch("out_value", 32'(seen_rsp.out_value),
                            32'(want.out_value));
          if (seen_rsp.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(seen_rsp.occupancy),
                            32'(want.occupancy));
        end
        rsp_index++;
      end
    end
    fail_count_o = mismatch_total;
    pending_o    = awaited_rsp.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the grouped team queue
// Drives directed and random operation streams with random idle gaps on both
// channels, holds the response side off for long stretches to back the block
// up, and gives the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb;
  import gtq_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  localparam int unsigned VALUE_MAX      = 999999;
  localparam int unsigned TEAM_MAX       = 1023;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned HOLD_FIRST_AT  = 100;
  localparam int unsigned HOLD_SECOND_AT = 1400;
  localparam int unsigned DRAIN_CYCLES   = 20;

  logic clk_i = 1'b0;
  logic rst_ni;

  gtq_req_if req_if ();
  gtq_rsp_if rsp_if ();

  int unsigned fail_count;
  int unsigned pending;

  // Stimulus bookkeeping
  bit                  calm;
  int unsigned         ops_sent;
  int unsigned         queue_depth;
  int unsigned         stall_cycles;
  logic [TEAMID_W-1:0] team_pool [8];
  logic [TEAMID_W-1:0] burst_team;

  grouped_team_queue u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  gtq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Idle span: mostly none or short, now and then long
  function automatic int unsigned idle_span();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Offer one request transaction and wait until it is taken
  task automatic issue(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                       input logic [TEAMID_W-1:0] team);
    int unsigned gap;
    gap = calm ? 0 : idle_span();
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.item_value <= value;
    req_if.team_id    <= team;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    ops_sent++;
    // track occupancy to steer the stream
    if (op == OP_ENQUEUE && queue_depth < CAPACITY) queue_depth++;
    if ((op == OP_DEQUEUE || op == OP_DISCARD) && queue_depth > 0) queue_depth--;
  endtask

  // Draw an operation by weight; enqueues come in same-team bursts
  task automatic issue_random(input int unsigned enq_pct, input int unsigned deq_pct,
                              input int unsigned disc_pct);
    int unsigned        roll;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) op = OP_ENQUEUE;
    else if (roll < enq_pct + deq_pct) op = OP_DEQUEUE;
    else if (roll < enq_pct + deq_pct + disc_pct) op = OP_DISCARD;
    else op = OP_RESERVED;
    if (op == OP_ENQUEUE) begin
      if ($urandom_range(0, 99) >= 60) begin
        if ($urandom_range(0, 3) != 0) burst_team = team_pool[$urandom_range(0, 7)];
        else burst_team = TEAMID_W'($urandom_range(0, TEAM_MAX));
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) value = '0;
      else if (roll < 14) value = VALUE_W'(VALUE_MAX);
      else value = VALUE_W'($urandom_range(0, VALUE_MAX));
      issue(op, value, burst_team);
    end else begin
      issue(op, VALUE_W'($urandom_range(0, VALUE_MAX)),
            TEAMID_W'($urandom_range(0, TEAM_MAX)));
    end
  endtask

  // Response side: random ready gaps plus two long hold-offs
  initial begin
    int unsigned holds_done;
    int unsigned on_span;
    int unsigned off_span;
    holds_done   = 0;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= 1'b1;
      on_span = calm ? 8 : $urandom_range(1, 6);
      repeat (on_span - 1) @(negedge clk_i);
      off_span = calm ? 0 : idle_span();
      if (holds_done < 2 &&
          ops_sent >= ((holds_done == 0) ? HOLD_FIRST_AT : HOLD_SECOND_AT)) begin
        off_span = HOLD_CYCLES;
        holds_done++;
      end
      if (off_span > 0) begin
        @(negedge clk_i);
        rsp_if.ready <= 1'b0;
        repeat (off_span - 1) @(negedge clk_i);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Reset, stimulus and verdict
  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.operation  = OP_ENQUEUE;
    req_if.item_value = '0;
    req_if.team_id    = '0;
    calm              = 1'b0;
    ops_sent          = 0;
    queue_depth       = 0;
    stall_cycles      = 0;
    for (int i = 0; i < 8; i++) team_pool[i] = TEAMID_W'($urandom_range(0, TEAM_MAX));
    team_pool[0] = '0;
    team_pool[7] = TEAMID_W'(TEAM_MAX);
    burst_team   = team_pool[$urandom_range(0, 7)];
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty removals and the reserved code
    issue(OP_DEQUEUE, '0, '0);
    issue(OP_DISCARD, VALUE_W'(VALUE_MAX), TEAMID_W'(TEAM_MAX));
    issue(OP_RESERVED, VALUE_W'(VALUE_MAX), TEAMID_W'(TEAM_MAX));
    // Build A C B E D F: grouping splices and plain tail appends
    issue(OP_ENQUEUE, '0, '0);
    issue(OP_ENQUEUE, VALUE_W'(VALUE_MAX), TEAMID_W'(TEAM_MAX));
    issue(OP_ENQUEUE, VALUE_W'(5), '0);
    issue(OP_ENQUEUE, VALUE_W'(20'h55555), TEAMID_W'(512));
    issue(OP_ENQUEUE, VALUE_W'(20'hAAAAA), TEAMID_W'(TEAM_MAX));
    issue(OP_ENQUEUE, VALUE_W'(7), TEAMID_W'(512));
    issue(OP_RESERVED, VALUE_W'(3), TEAMID_W'(1));
    // Head leaves; team mark survives, then clears when the block ends
    issue(OP_DEQUEUE, '0, '0);
    issue(OP_DISCARD, '0, '0);
    // Team 0 is gone from the queue, so this one goes to the tail
    issue(OP_ENQUEUE, VALUE_W'(9), '0);
    issue(OP_DEQUEUE, '0, '0);
    issue(OP_DEQUEUE, '0, '0);
    issue(OP_DEQUEUE, '0, '0);
    issue(OP_DEQUEUE, '0, '0);
    issue(OP_DISCARD, '0, '0);
    issue(OP_DEQUEUE, '0, '0);
    // Single-element queue: remove the only node
    issue(OP_ENQUEUE, VALUE_W'(1), TEAMID_W'(7));
    issue(OP_DEQUEUE, '0, '0);

    // Random mix near empty, the first stretch with no idling
    calm = 1'b1;
    for (int i = 0; i < 150; i++) begin
      if (i == 40) calm = 1'b0;
      issue_random(45, 25, 22);
    end

    // Fill to capacity, then knock on a full queue
    while (queue_depth < CAPACITY) issue_random(92, 4, 4);
    repeat (3) issue_random(100, 0, 0);

    // Churn near full: hits full often and recycles freed slots
    for (int i = 0; i < 150; i++) begin
      calm = (i >= 50 && i < 100);
      issue_random(47, 25, 20);
    end
    calm = 1'b0;

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
